// File: design/cha_pkg.sv
// ----------------------------------------------------------------------------
// cha_pkg
// Shared constants for the circular heading average block: default ring
// depth and binary angle width.
// ----------------------------------------------------------------------------
package cha_pkg;

	localparam int CHA_RING_DEPTH = 8;
	localparam int CHA_ANGLE_BITS = 16;

endpackage

// File: design/circular_heading_average_core.sv
// ----------------------------------------------------------------------------
// circular_heading_average_core
// Wraparound-aware moving average of binary angle headings over a ring.
//
// Input channel heading_sample (valid/ready) takes one signed binary angle per
// transfer; the full range spans one turn. Output channel filtered_heading
// (valid/ready) returns one averaged heading per input, in order.
// The ring lives in a single-port-write, registered-read memory. Each item
// writes its sample, then streams all RING_DEPTH entries through one adder,
// then divides the sum by RING_DEPTH. Slot 0 decides whether the whole ring
// is averaged rotated by half a turn.
// The sweep reads one entry per cycle from the memory read port. For a
// power-of-two depth the division is a shift; otherwise it yields one
// quotient digit per cycle. The first sample after reset writes every slot.
// One item is in flight at a time; ready returns once the result is loaded.
// Reset clears the control state; the first sample fills the ring. A stalled
// receiver holds the result in the output register while the next item is
// processed; that result then waits until the register frees.
// ----------------------------------------------------------------------------
module circular_heading_average_core
	import cha_pkg::*;
#(
	parameter int RING_DEPTH = CHA_RING_DEPTH,
	parameter int ANGLE_BITS = CHA_ANGLE_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         heading_sample_valid,
	output logic                         heading_sample_ready,
	input  logic signed [ANGLE_BITS-1:0] heading_sample,
	output logic                         filtered_heading_valid,
	input  logic                         filtered_heading_ready,
	output logic signed [ANGLE_BITS-1:0] filtered_heading
);

	localparam int IW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int LOG_D = $clog2(RING_DEPTH);
	localparam int W     = ANGLE_BITS + LOG_D;
	localparam bit DEPTH_POW2 = ((RING_DEPTH & (RING_DEPTH - 1)) == 0);
	localparam logic [IW-1:0] LAST_IDX = IW'(RING_DEPTH - 1);
	localparam logic [ANGLE_BITS-1:0] TOP = {1'b1, {(ANGLE_BITS-1){1'b0}}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_WRITE,
		ST_READ,
		ST_ACCUM,
		ST_DIVIDE
	} state_t;

	state_t                  state_q;
	logic                    primed_q;
	logic [IW-1:0]           widx_q;
	logic [IW-1:0]           addr_q;
	logic [ANGLE_BITS-1:0]   sample_q;
	logic [W-1:0]            acc_q;
	logic                    rotate_q;
	logic                    out_valid_q;
	logic [ANGLE_BITS-1:0]   out_q;

	logic                    rd_valid_s1;
	logic                    rd_first_s1;
	logic [ANGLE_BITS-1:0]   rdata_s1;

	logic [ANGLE_BITS-1:0]   ring [RING_DEPTH];

	logic                    mem_we;
	logic [IW-1:0]           mem_waddr;
	logic                    mem_re;
	logic [IW-1:0]           next_idx;
	logic                    rot_now;
	logic                    rot_sel;
	logic [ANGLE_BITS-1:0]   addend;
	logic                    in_xfer;
	logic                    out_xfer;
	logic                    in_divide;
	logic                    div_done;
	logic [ANGLE_BITS-1:0]   div_quo;
	logic                    out_load;

	assign in_xfer   = heading_sample_valid && heading_sample_ready;
	assign out_xfer  = filtered_heading_valid && filtered_heading_ready;
	assign in_divide = (state_q == ST_DIVIDE);
	assign out_load  = in_divide && div_done && (!out_valid_q || filtered_heading_ready);

	assign heading_sample_ready   = (state_q == ST_IDLE);
	assign filtered_heading_valid = out_valid_q;
	assign filtered_heading       = out_q;

	assign next_idx  = (widx_q == LAST_IDX) ? '0 : widx_q + IW'(1);
	assign mem_we    = (state_q == ST_FILL) || (state_q == ST_WRITE);
	assign mem_waddr = (state_q == ST_FILL) ? addr_q : next_idx;
	assign mem_re    = (state_q == ST_READ);

	// slot 0 at or beyond a quarter turn either way
	assign rot_now = (rdata_s1[ANGLE_BITS-1] ^ rdata_s1[ANGLE_BITS-2])
		|| (rdata_s1[ANGLE_BITS-1] && rdata_s1[ANGLE_BITS-2]
			&& (rdata_s1[ANGLE_BITS-3:0] == '0));
	assign rot_sel = rd_first_s1 ? rot_now : rotate_q;
	// offset-binary addend keeps the running sum non-negative
	assign addend  = rot_sel ? rdata_s1 : (rdata_s1 ^ TOP);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			ring[mem_waddr] <= sample_q;
		end
		if (mem_re) begin
			rdata_s1 <= ring[addr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			primed_q    <= 1'b0;
			widx_q      <= '0;
			addr_q      <= '0;
			out_valid_q <= 1'b0;
			rd_valid_s1 <= 1'b0;
			rd_first_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= mem_re;
			rd_first_s1 <= mem_re && (addr_q == '0);

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_xfer) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					addr_q <= '0;
					if (in_xfer) begin
						state_q <= primed_q ? ST_WRITE : ST_FILL;
					end
				end
				ST_FILL: begin
					if (addr_q == LAST_IDX) begin
						addr_q   <= '0;
						widx_q   <= '0;
						primed_q <= 1'b1;
						state_q  <= ST_READ;
					end else begin
						addr_q <= addr_q + IW'(1);
					end
				end
				ST_WRITE: begin
					widx_q  <= next_idx;
					addr_q  <= '0;
					state_q <= ST_READ;
				end
				ST_READ: begin
					if (addr_q == LAST_IDX) begin
						state_q <= ST_ACCUM;
					end else begin
						addr_q <= addr_q + IW'(1);
					end
				end
				ST_ACCUM: begin
					state_q <= ST_DIVIDE;
				end
				ST_DIVIDE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sample_q <= heading_sample;
		end
		if (rd_valid_s1) begin
			acc_q    <= rd_first_s1 ? W'(addend) : acc_q + W'(addend);
			rotate_q <= rot_sel;
		end
		if (out_load) begin
			// drop the offset, then undo the half-turn rotation
			out_q <= rotate_q ? div_quo : (div_quo ^ TOP);
		end
	end

	generate
		if (DEPTH_POW2) begin : g_shift
			assign div_done = 1'b1;
			assign div_quo  = acc_q[LOG_D +: ANGLE_BITS];
		end else begin : g_digit
			localparam int ND    = (W + 3) / 4;
			localparam int NW    = 4 * ND;
			localparam int TW    = LOG_D + 4;
			localparam int STEPS = ND + 1;
			localparam int SW    = $clog2(STEPS + 1);
			localparam logic [SW-1:0] LAST_STEP = SW'(STEPS);

			logic [SW-1:0]         step_q;
			logic [NW-1:0]         num_q;
			logic [LOG_D-1:0]      rem_q;
			logic [ANGLE_BITS-1:0] quo_q;
			logic [TW-1:0]         trial;
			logic [TW-1:0]         take;
			logic [TW-1:0]         rest;
			logic [3:0]            digit;

			assign trial    = {rem_q, num_q[NW-1 -: 4]};
			assign rest     = trial - take;
			assign div_done = (step_q == LAST_STEP);
			assign div_quo  = quo_q;

			// take the largest multiple of the depth that fits
			always_comb begin
				digit = '0;
				take  = '0;
				for (int j = 1; j < 16; j++) begin
					if (trial >= TW'(j * RING_DEPTH)) begin
						digit = 4'(j);
						take  = TW'(j * RING_DEPTH);
					end
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					step_q <= '0;
				end else if (!in_divide) begin
					step_q <= '0;
				end else if (step_q != LAST_STEP) begin
					step_q <= step_q + SW'(1);
				end
			end

			always_ff @(posedge clk) begin
				if (step_q == '0) begin
					num_q <= NW'(acc_q);
					rem_q <= '0;
				end else if (in_divide && (step_q != LAST_STEP)) begin
					num_q <= {num_q[NW-5:0], 4'b0000};
					rem_q <= rest[LOG_D-1:0];
					quo_q <= {quo_q[ANGLE_BITS-5:0], digit};
				end
			end
		end
	endgenerate

	a_accept_starts_write: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == ST_FILL || state_q == ST_WRITE))
		else $error("input transfer did not start a ring write");

	a_fill_only_unprimed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FILL) |-> !primed_q)
		else $error("ring fill while already primed");

	a_write_only_primed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |-> primed_q)
		else $error("single-slot write before priming");

	a_read_data_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> (state_q == ST_READ || state_q == ST_ACCUM))
		else $error("read data outside the read sweep");

	a_load_frees_output: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !filtered_heading_ready) |-> !out_load)
		else $error("result loaded over a held output");

endmodule

// File: sim/heading_average_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// heading_average_checker
// Watches both channels of the circular heading average core. Every sample
// transfer updates a local copy of the heading ring and queues the expected
// wraparound-aware mean. Every result transfer is compared against the oldest
// queued mean. Mismatches and unexpected results are counted and handed up.
// ----------------------------------------------------------------------------
module heading_average_checker
	import cha_pkg::*;
(
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             sample_valid,
	input  logic                             sample_ready,
	input  logic signed [CHA_ANGLE_BITS-1:0] sample,
	input  logic                             mean_valid,
	input  logic                             mean_ready,
	input  logic signed [CHA_ANGLE_BITS-1:0] mean,
	output int                               mismatch_count,
	output int                               outstanding
);

	localparam int DEPTH = CHA_RING_DEPTH;
	localparam int BITS = CHA_ANGLE_BITS;
	localparam longint QUARTER_TURN = longint'(1) << (BITS - 2);

	typedef logic signed [BITS-1:0] angle_t;

	angle_t      heading_ring [DEPTH];
	int unsigned ring_slot;
	bit          ring_primed;
	angle_t      expected_headings [$];

	function automatic angle_t half_turn(input angle_t a);
		angle_t r;
		r = a;
		r[BITS-1] = ~r[BITS-1];
		return r;
	endfunction

	task automatic store_and_average(input angle_t h, output angle_t avg);
		longint sum;
		longint q;
		bit     rotate;
		if (!ring_primed) begin
			for (int i = 0; i < DEPTH; i++)
				heading_ring[i] = h;
			ring_slot = 0;
			ring_primed = 1'b1;
		end else begin
			ring_slot = (ring_slot + 1) % DEPTH;
			heading_ring[ring_slot] = h;
		end
		rotate = (heading_ring[0] >= QUARTER_TURN) || (heading_ring[0] <= -QUARTER_TURN);
		sum = 0;
		for (int i = 0; i < DEPTH; i++)
			sum += longint'(rotate ? half_turn(heading_ring[i]) : heading_ring[i]);
		q = sum / DEPTH;
		if ((sum % DEPTH) != 0 && sum < 0)
			q -= 1;
		avg = angle_t'(q);
		if (rotate)
			avg = half_turn(avg);
	endtask

	task automatic note_mismatch(input angle_t want, input angle_t got, input bit orphan);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			if (orphan)
				$display("%0t: filtered_heading %0d with no result pending", $realtime, got);
			else
				$display("%0t: filtered_heading expected %0d, got %0d", $realtime, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		angle_t predicted;
		angle_t want;
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++)
				heading_ring[i] = '0;
			ring_slot = 0;
			ring_primed = 1'b0;
			expected_headings.delete();
			mismatch_count = 0;
			outstanding = 0;
		end else begin
			if (sample_valid && sample_ready) begin
				store_and_average(sample, predicted);
				expected_headings.push_back(predicted);
			end
			if (mean_valid && mean_ready) begin
				if (expected_headings.size() == 0) begin
					note_mismatch('0, mean, 1'b1);
				end else begin
					want = expected_headings.pop_front();
					if (mean !== want)
						note_mismatch(want, mean, 1'b0);
				end
			end
			outstanding = expected_headings.size();
		end
	end

endmodule

// File: sim/tb_circular_heading_average_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circular_heading_average_core
// Drives heading samples into the circular heading average core: a directed
// run over angle extremes and the rotate threshold, then random samples mixed
// from uniform, clustered, near half-turn and near quarter-turn values. Both
// channels idle at random; a checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_circular_heading_average_core
	import cha_pkg::*;
();

	localparam int BITS = CHA_ANGLE_BITS;
	localparam int RANDOM_HEADINGS = 1030;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE_CYCLES = 2 * CHA_RING_DEPTH + 8;

	typedef logic signed [BITS-1:0] angle_t;
	typedef enum int {MIX_UNIFORM, MIX_CLUSTER, MIX_NEAR_PI, MIX_NEAR_QUARTER} heading_mix_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   heading_sample_valid = 1'b0;
	logic   heading_sample_ready;
	angle_t heading_sample = '0;
	logic   filtered_heading_valid;
	logic   filtered_heading_ready = 1'b0;
	angle_t filtered_heading;

	int           mismatch_count;
	int           outstanding;
	int           cycle_count = 0;
	int           drain_stall = 0;
	bit           drain_steady = 1'b0;
	bit           feed_steady = 1'b0;
	heading_mix_t mix;
	angle_t       center;

	int directed_headings [25] = '{
		16384, 32767, -32768, 0, -1, 1, 32000, -32000,
		16383, -32768, 32767, -32768, 32767, -32768, 32767, -32768,
		-16384, 30000, -30000, 32767, -32768, 16384, -16384, 5,
		-16383
	};

	circular_heading_average_core dut (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.heading_sample_valid   (heading_sample_valid),
		.heading_sample_ready   (heading_sample_ready),
		.heading_sample         (heading_sample),
		.filtered_heading_valid (filtered_heading_valid),
		.filtered_heading_ready (filtered_heading_ready),
		.filtered_heading       (filtered_heading)
	);

	heading_average_checker heading_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (heading_sample_valid),
		.sample_ready   (heading_sample_ready),
		.sample         (heading_sample),
		.mean_valid     (filtered_heading_valid),
		.mean_ready     (filtered_heading_ready),
		.mean           (filtered_heading),
		.mismatch_count (mismatch_count),
		.outstanding    (outstanding)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	function automatic int pick_pause();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 75)
			return $urandom_range(1, 3);
		if (roll < 95)
			return $urandom_range(4, 8);
		return $urandom_range(20, 60);
	endfunction

	function automatic angle_t next_heading(input heading_mix_t m, input angle_t c);
		case (m)
			MIX_UNIFORM:   return angle_t'($urandom);
			MIX_CLUSTER:   return angle_t'(int'(c) + int'($urandom_range(0, 4096)) - 2048);
			MIX_NEAR_PI:   return angle_t'(32768 + int'($urandom_range(0, 6000)) - 3000);
			default:       return angle_t'(($urandom_range(0, 1) ? 16384 : -16384)
				+ int'($urandom_range(0, 8)) - 4);
		endcase
	endfunction

	// hold valid and payload until the transfer, then idle for a random gap, which may be zero
	task automatic send_heading(input angle_t h);
		int gap;
		heading_sample <= h;
		heading_sample_valid <= 1'b1;
		do @(posedge clk); while (!heading_sample_ready);
		@(negedge clk);
		gap = (feed_steady || $urandom_range(0, 99) < 55) ? 0 : pick_pause();
		if (gap > 0) begin
			heading_sample_valid <= 1'b0;
			heading_sample <= angle_t'($urandom);
			repeat (gap) @(negedge clk);
		end
	endtask

	always @(negedge clk) begin
		if (drain_stall > 0) begin
			filtered_heading_ready <= 1'b0;
			drain_stall <= drain_stall - 1;
		end else begin
			filtered_heading_ready <= 1'b1;
			if (!drain_steady && $urandom_range(0, 99) < 20)
				drain_stall <= pick_pause();
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		$display("FAIL");
		$finish;
	end

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (directed_headings[i])
			send_heading(angle_t'(directed_headings[i]));
		for (int n = 0; n < RANDOM_HEADINGS; n++) begin
			if (n % 64 == 0) begin
				feed_steady = ($urandom_range(0, 3) == 0);
				drain_steady <= ($urandom_range(0, 3) == 0);
			end
			if (n % 8 == 0) begin
				mix = heading_mix_t'($urandom_range(0, 3));
				center = angle_t'($urandom);
			end
			// drain everything in flight before continuing
			if (n == RANDOM_HEADINGS / 2) begin
				heading_sample_valid <= 1'b0;
				do @(negedge clk); while (outstanding != 0);
			end
			send_heading(next_heading(mix, center));
		end
		heading_sample_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && outstanding == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
